// File: hw/rtl/dwc_pkg.sv
// Shared types, codes and defaults for the 3x3 depthwise convolution stream block.
package dwc_pkg;

    // Default frame size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Depth of the window queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_W_TOP    = 3'd0;
    localparam logic [2:0] CFG_W_MID    = 3'd1;
    localparam logic [2:0] CFG_W_BOT    = 3'd2;
    localparam logic [2:0] CFG_CH_BIAS  = 3'd3;
    localparam logic [2:0] CFG_BIAS_MD  = 3'd4;
    localparam logic [2:0] CFG_ACT      = 3'd5;
    localparam logic [2:0] CFG_IMG_W    = 3'd6;
    localparam logic [2:0] CFG_IMG_H    = 3'd7;

    // Bias mode codes
    localparam logic [1:0] BIAS_CHANNEL = 2'd1;
    localparam logic [1:0] BIAS_PIXEL   = 2'd2;

    // Activation codes
    localparam logic [1:0] ACT_RELU     = 2'd1;
    localparam logic [1:0] ACT_HSWISH   = 2'd2;

    // Item kind
    localparam logic OP_DRAIN = 1'b1;

    // 3x3 window, [row][column], Q8.8 samples
    typedef logic [2:0][2:0][15:0] t_win;

    // One queue entry: window after the item plus what its outputs need
    typedef struct packed {
        t_win        win;
        logic [15:0] bias_a;      // bias for the output left of the new column
        logic [15:0] bias_b;      // bias for the row-end output
        logic        has_a;
        logic        has_b;
        logic        frame_done;
    } t_job;

endpackage

// File: hw/rtl/depthwise_conv3x3_pad1_stream.sv
// One channel of a 3x3 stride-1 depthwise convolution with zero padding over a
// raster-order Q8.8 frame. The front end takes a new request only once it is done with the
// last one (the line buffer read is registered) and only while the queue is not full; a
// request with an output due issues a window job into a 2-deep queue. The back end computes
// one output with 9 serial multiplies, rounding and activation (2 more steps with hard-swish)
// and holds it in an output register, so a row's sustained rate is set by the single
// multiply-accumulate unit. Output (h,w) follows input (h+1,w+1); a row end yields two outputs.
// After the frame, send W drain requests (tuser=1) for the zero bottom row. No clearing pass after reset.
module depthwise_conv3x3_pad1_stream #(
    parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dwc_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample [15:0], pixel_bias [31:16]
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result [15:0]
    output logic        m_axis_tlast,   // last_in_run
    output logic        m_axis_tuser,   // frame_done
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [2:0][47:0] r_weights;
    logic [15:0]      r_chan_bias;
    logic [1:0]       r_bias_mode;
    logic [1:0]       r_act;
    logic [10:0]      r_img_w;
    logic [10:0]      r_img_h;

    logic [CW-1:0]    width_eff;
    logic [RW-1:0]    height_eff;
    logic             geo_wr;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    dwc_pkg::t_job    job_in;
    dwc_pkg::t_job    job_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights   <= '0;
            r_chan_bias <= '0;
            r_bias_mode <= '0;
            r_act       <= '0;
            r_img_w     <= 11'd2;
            r_img_h     <= 11'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dwc_pkg::CFG_W_TOP:   r_weights[0] <= i_cfg_data;
                dwc_pkg::CFG_W_MID:   r_weights[1] <= i_cfg_data;
                dwc_pkg::CFG_W_BOT:   r_weights[2] <= i_cfg_data;
                dwc_pkg::CFG_CH_BIAS: r_chan_bias  <= i_cfg_data[15:0];
                dwc_pkg::CFG_BIAS_MD: r_bias_mode  <= i_cfg_data[1:0];
                dwc_pkg::CFG_ACT:     r_act        <= i_cfg_data[1:0];
                dwc_pkg::CFG_IMG_W:   r_img_w      <= i_cfg_data[10:0];
                dwc_pkg::CFG_IMG_H:   r_img_h      <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign geo_wr = i_cfg_we &&
                    ((i_cfg_index == dwc_pkg::CFG_IMG_W) || (i_cfg_index == dwc_pkg::CFG_IMG_H));

    // Frame size clamped to the supported range
    always_comb begin
        if (r_img_w < 11'd2) begin
            width_eff = CW'(2);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(r_img_w);
        end
        if (r_img_h < 11'd2) begin
            height_eff = RW'(2);
        end else if (32'(r_img_h) > MAX_HEIGHT) begin
            height_eff = RW'(MAX_HEIGHT);
        end else begin
            height_eff = RW'(r_img_h);
        end
    end

    dwc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_sample    (s_axis_tdata[15:0]),
        .i_pbias     (s_axis_tdata[31:16]),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_geo_wr    (geo_wr),
        .i_bias_mode (r_bias_mode),
        .i_chan_bias (r_chan_bias),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job_in)
    );

    dwc_queue #(.DEPTH(dwc_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dwc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .i_job        (job_out),
        .i_weights    (r_weights),
        .i_act        (r_act),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_result     (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_frame_done (m_axis_tuser)
    );

endmodule

// File: hw/rtl/dwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/dwc_front.sv
// Front end: accepts items, keeps line buffers and window, queues output jobs.
module dwc_front #(
    parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dwc_pkg::MAX_HEIGHT_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic [15:0]   i_sample,
    input  logic [15:0]   i_pbias,
    input  logic [CW-1:0] i_width,
    input  logic [RW-1:0] i_height,
    input  logic          i_geo_wr,
    input  logic [1:0]    i_bias_mode,
    input  logic [15:0]   i_chan_bias,
    input  logic          i_q_full,
    output logic          o_push,
    output dwc_pkg::t_job o_job
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state        r_state;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_w;
    logic          r_ok;
    logic          r_drain;
    logic [15:0]   r_s;
    logic [15:0]   r_pb;
    logic [15:0]   r_held;
    dwc_pkg::t_win r_win;

    logic [CW-1:0] w_cur;
    logic          drain;
    logic          accept;
    logic          exec_ok;
    logic [15:0]   above_q;
    logic [15:0]   cur_q;
    logic [15:0]   bias_q;
    logic [15:0]   top;
    dwc_pkg::t_win n_win;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    function automatic logic [15:0] pick_bias(input logic [1:0] mode, input logic [15:0] pix,
                                              input logic [15:0] chan);
        logic [15:0] b;
        case (mode)
            dwc_pkg::BIAS_CHANNEL: b = chan;
            dwc_pkg::BIAS_PIXEL:   b = pix;
            default:               b = '0;
        endcase
        return b;
    endfunction

    // Column index of the incoming item, wrapped if the width shrank
    assign w_cur   = (r_col >= i_width) ? '0 : r_col;
    assign drain   = (r_row >= i_height);
    assign o_ready = (r_state == S_IDLE) && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign exec_ok = (r_state == S_EXEC) && r_ok;

    // Line buffers and bias delay line
    dwc_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_above (
        .i_clk(i_clk), .i_we(exec_ok), .i_waddr(r_w[AW-1:0]), .i_wdata(cur_q),
        .i_raddr(w_cur[AW-1:0]), .o_rdata(above_q)
    );
    dwc_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_cur (
        .i_clk(i_clk), .i_we(exec_ok), .i_waddr(r_w[AW-1:0]), .i_wdata(r_s),
        .i_raddr(w_cur[AW-1:0]), .o_rdata(cur_q)
    );
    dwc_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_bias (
        .i_clk(i_clk), .i_we(exec_ok), .i_waddr(r_w[AW-1:0]), .i_wdata(r_pb),
        .i_raddr(w_cur[AW-1:0]), .o_rdata(bias_q)
    );

    // Window shift and new column
    assign top = (r_row >= RW'(2)) ? above_q : '0;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_w == '0) begin
                n_win[k][0] = '0;
                n_win[k][1] = '0;
            end else begin
                n_win[k][0] = r_win[k][1];
                n_win[k][1] = r_win[k][2];
            end
        end
        n_win[0][2] = top;
        n_win[1][2] = cur_q;
        n_win[2][2] = r_s;
    end

    // Job for the queue
    always_comb begin
        o_job.win        = n_win;
        o_job.bias_a     = pick_bias(i_bias_mode, r_held, i_chan_bias);
        o_job.bias_b     = pick_bias(i_bias_mode, bias_q, i_chan_bias);
        o_job.has_a      = (r_row != '0) && (r_w != '0);
        o_job.has_b      = (r_row != '0) && (r_w == i_width - CW'(1));
        o_job.frame_done = r_drain;
    end
    assign o_push = exec_ok && (o_job.has_a || o_job.has_b);

    // Position counters after this item
    always_comb begin
        n_col = r_w + CW'(1);
        n_row = r_row;
        if (n_col >= i_width) begin
            n_col = '0;
            n_row = r_row + RW'(1);
            if (n_row > i_height) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_ok    <= 1'b0;
            r_win   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ok    <= ((i_op == dwc_pkg::OP_DRAIN) == drain);
                        r_drain <= drain;
                        r_w     <= w_cur;
                        r_s     <= drain ? '0 : i_sample;
                        r_pb    <= i_pbias;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_ok) begin
                        r_win  <= n_win;
                        r_held <= bias_q;
                        r_col  <= n_col;
                        r_row  <= n_row;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // Geometry change restarts the frame
            if (i_geo_wr) begin
                r_col <= '0;
                r_row <= '0;
            end
        end
    end

endmodule

// File: hw/rtl/dwc_queue.sv
// Short FIFO of window jobs between front and back.
module dwc_queue #(
    parameter int DEPTH = dwc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dwc_pkg::t_job i_job,
    input  logic          i_pop,
    output dwc_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    dwc_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + NW'(i_push) - NW'(i_pop);
        end
    end

endmodule

// File: hw/rtl/dwc_back.sv
// Back end: serial multiply-accumulate, rounding, activation and output register.
module dwc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  dwc_pkg::t_job     i_job,
    input  logic [2:0][47:0]  i_weights,
    input  logic [1:0]        i_act,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [15:0]       o_result,
    output logic              o_last,
    output logic              o_frame_done
);

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_RND, S_ACT1, S_ACT2, S_ACT3, S_OUT} t_state;

    t_state               r_state;
    dwc_pkg::t_job        r_job;
    logic                 r_sec;
    logic [3:0]           r_cnt;
    logic [1:0]           r_k;
    logic [1:0]           r_j;
    logic signed [31:0]   r_prod;
    logic signed [35:0]   r_acc;
    logic signed [15:0]   r_x;
    logic signed [27:0]   r_hp;
    logic [34:0]          r_v;

    logic signed [15:0]   opnd;
    logic signed [15:0]   wgt;
    logic signed [27:0]   y;
    logic signed [16:0]   xt;
    logic [10:0]          t;
    logic signed [27:0]   hp_off;
    logic signed [17:0]   q;
    logic signed [15:0]   x_act;

    function automatic logic [15:0] sat16(input logic signed [27:0] v);
        logic [15:0] r;
        if (v > 28'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -28'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [35:0] bias_acc(input logic [15:0] b);
        return {{12{b[15]}}, b, 8'b0};
    endfunction

    // Tap operand: second output shifts the window left, dropping the left column, and zero-fills the right column
    always_comb begin
        if (!r_sec) begin
            opnd = r_job.win[r_k][r_j];
        end else if (r_j == 2'd2) begin
            opnd = '0;
        end else begin
            opnd = r_job.win[r_k][r_j + 2'd1];
        end
        wgt = i_weights[r_k][16*r_j +: 16];
    end

    // Round to nearest Q8.8
    assign y = 28'((r_acc + 36'sd128) >>> 8);

    // Hard-swish pieces
    assign xt     = 17'(r_x) + 17'sd768;
    assign t      = (xt < 0) ? '0 : (xt > 17'sd1536) ? 11'd1536 : xt[10:0];
    assign hp_off = r_hp + 28'sd197376;
    assign q      = $signed({1'b0, r_v[34:18]}) - 18'sd128;

    always_comb begin
        case (i_act)
            dwc_pkg::ACT_RELU: x_act = r_x[15] ? '0 : r_x;
            default:           x_act = r_x;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_sec   <= !i_job.has_a;
                        r_acc   <= bias_acc(i_job.has_a ? i_job.bias_a : i_job.bias_b);
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_cnt != 4'd0) begin
                        r_acc <= r_acc + 36'(r_prod);
                    end
                    if (r_cnt != 4'd9) begin
                        r_prod <= opnd * wgt;
                        r_cnt  <= r_cnt + 4'd1;
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            r_k <= r_k + 2'd1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end else begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_x     <= sat16(y);
                    r_state <= S_ACT1;
                end
                S_ACT1: begin
                    if (i_act == dwc_pkg::ACT_HSWISH) begin
                        r_hp    <= r_x * $signed({1'b0, t});
                        r_state <= S_ACT2;
                    end else begin
                        o_result     <= x_act;
                        o_last       <= r_sec || !r_job.has_b;
                        o_frame_done <= r_sec && r_job.frame_done;
                        o_tvalid     <= 1'b1;
                        r_state      <= S_OUT;
                    end
                end
                S_ACT2: begin
                    // floor(p / 1536) as floor(floor(p / 512) / 3)
                    r_v     <= hp_off[25:9] * 18'd87382;
                    r_state <= S_ACT3;
                end
                S_ACT3: begin
                    o_result     <= sat16(28'(q));
                    o_last       <= r_sec || !r_job.has_b;
                    o_frame_done <= r_sec && r_job.frame_done;
                    o_tvalid     <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (i_tready) begin
                        o_tvalid <= 1'b0;
                        if (!r_sec && r_job.has_b) begin
                            r_sec   <= 1'b1;
                            r_acc   <= bias_acc(r_job.bias_b);
                            r_cnt   <= '0;
                            r_k     <= '0;
                            r_j     <= '0;
                            r_state <= S_MAC;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
